// ===== hw/rtl/slkt_pkg.sv =====
// Package for the shared/exclusive lock table: field widths, default sizes,
// operation and mode codes, controller-to-datapath command struct.
// No dependencies.
`default_nettype none

package slkt_pkg;

    // fixed item field widths
    localparam int TXN_ID_W = 16;
    localparam int KEY_W    = 64;
    localparam int LEN_W    = 4;
    localparam int COUNT_W  = 5;

    // default table geometry
    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_KEY_BYTES     = 8;
    localparam int DEF_TXN_BITS      = 16;

    // operation codes
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // lock modes
    localparam logic MODE_SHARED    = 1'b0;
    localparam logic MODE_EXCLUSIVE = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;    // capture the incoming request
        logic cmp_en;  // table read data valid for cmp address
        logic commit;  // apply the decision and load the result register
    } slkt_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slkt_if.sv =====
// Request and response channel interfaces (valid/ready) for the lock table.
// Depends on slkt_pkg.
`default_nettype none

interface slkt_req_if import slkt_pkg::*;;
    logic                valid;
    logic                ready;
    logic                operation;
    logic [TXN_ID_W-1:0] txn_id;
    logic [KEY_W-1:0]    lock_key;
    logic [LEN_W-1:0]    key_length;
    logic                lock_mode;

    modport source (output valid, operation, txn_id, lock_key, key_length, lock_mode,
                    input ready);
    modport sink   (input valid, operation, txn_id, lock_key, key_length, lock_mode,
                    output ready);
endinterface

interface slkt_rsp_if import slkt_pkg::*;;
    logic               valid;
    logic               ready;
    logic               granted;
    logic               table_full;
    logic [COUNT_W-1:0] lock_count;
    logic [COUNT_W-1:0] released_count;

    modport source (output valid, granted, table_full, lock_count, released_count,
                    input ready);
    modport sink   (input valid, granted, table_full, lock_count, released_count,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/slkt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module slkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/slkt_ctrl.sv =====
// Sequencing controller for the lock table: walks the table one entry per
// cycle, then commits and hands the result to the output register.
// Depends on slkt_pkg.
`default_nettype none

module slkt_ctrl import slkt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    output logic                             out_valid,
    input  logic                             out_ready,
    output slkt_cmd_t                        cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
    output logic [$clog2(TABLE_ENTRIES)-1:0] cmp_addr
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_COMMIT} state_t;

    state_t        state_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] cmp_addr_reg;
    logic          cmp_en_reg;
    logic          out_valid_reg;
    logic          out_free;

    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && in_valid;
    assign cmd.cmp_en = cmp_en_reg;
    assign cmd.commit = (state_reg == S_COMMIT) && out_free;
    assign rd_addr    = idx_reg;
    assign cmp_addr   = cmp_addr_reg;
    assign out_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cmp_addr_reg  <= '0;
            cmp_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // read data arrives in the cycle after its address
            cmp_en_reg   <= (state_reg == S_SCAN);
            cmp_addr_reg <= idx_reg;

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + AW'(1);
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/slkt_dp.sv =====
// Lock table datapath: request registers, entry RAM, valid bits, lock
// count, per-scan match/conflict/free-slot tracking and the result register.
// Depends on slkt_pkg and slkt_ram.
`default_nettype none

module slkt_dp import slkt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int KEY_BYTES     = DEF_KEY_BYTES,
    parameter int TXN_BITS      = DEF_TXN_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  slkt_cmd_t                        cmd,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] cmp_addr,
    input  logic                             operation,
    input  logic [TXN_ID_W-1:0]              txn_id,
    input  logic [KEY_W-1:0]                 lock_key,
    input  logic [LEN_W-1:0]                 key_length,
    input  logic                             lock_mode,
    output logic                             granted,
    output logic                             table_full,
    output logic [COUNT_W-1:0]               lock_count,
    output logic [COUNT_W-1:0]               released_count
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int TXN_W = (TXN_BITS < TXN_ID_W) ? TXN_BITS : TXN_ID_W;
    localparam int KW    = KEY_BYTES * 8;
    localparam int RAM_W = TXN_W + KW + LEN_W + 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(KEY_BYTES);

    // request
    logic             req_op_reg;
    logic [TXN_W-1:0] req_txn_reg;
    logic [KW-1:0]    req_key_reg;
    logic [LEN_W-1:0] req_len_reg;
    logic             req_excl_reg;

    logic [LEN_W-1:0] len_norm;
    logic [KW-1:0]    key_norm;

    // scan results
    logic             held_reg;
    logic             conflict_reg;
    logic             free_found_reg;
    logic [AW-1:0]    free_slot_reg;
    logic [CNT_W-1:0] rel_cnt_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    // result register
    logic               granted_reg;
    logic               full_reg;
    logic [COUNT_W-1:0] lock_count_reg;
    logic [COUNT_W-1:0] released_reg;

    // entry RAM word and compare
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;
    logic [TXN_W-1:0] e_txn;
    logic [KW-1:0]    e_key;
    logic [LEN_W-1:0] e_len;
    logic             e_excl;
    logic             e_valid;
    logic             key_match;
    logic             txn_match;
    logic             alloc;
    logic [31:0]      count_wide;
    logic [31:0]      rel_wide;

    // clamp length, clear bytes beyond it
    assign len_norm = (key_length > MAX_LEN) ? MAX_LEN : key_length;

    always_comb
    begin
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            key_norm[8*b +: 8] = (b < int'(len_norm)) ? lock_key[8*b +: 8] : 8'h00;
        end
    end

    assign ram_wdata = {req_txn_reg, req_key_reg, req_len_reg, req_excl_reg};
    assign {e_txn, e_key, e_len, e_excl} = ram_rdata;

    slkt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (alloc),
        .waddr (free_slot_reg),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign e_valid   = valid_reg[cmp_addr];
    assign txn_match = (e_txn == req_txn_reg);
    assign key_match = (e_len == req_len_reg) && (e_key == req_key_reg);

    assign alloc = cmd.commit && (req_op_reg == OP_ACQUIRE) && !held_reg &&
                   !conflict_reg && free_found_reg;

    always_comb
    begin
        count_next = count_reg;
        if (req_op_reg == OP_RELEASE)
        begin
            count_next = count_reg - rel_cnt_reg;
        end
        else if (alloc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    assign count_wide = 32'(count_next);
    assign rel_wide   = 32'(rel_cnt_reg);

    // request and scan state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_op_reg   <= operation;
            req_txn_reg  <= txn_id[TXN_W-1:0];
            req_key_reg  <= key_norm;
            req_len_reg  <= len_norm;
            req_excl_reg <= (lock_mode == MODE_EXCLUSIVE);
        end
        if (cmd.commit)
        begin
            granted_reg    <= (req_op_reg == OP_RELEASE) || held_reg || alloc;
            full_reg       <= (req_op_reg == OP_ACQUIRE) && !held_reg &&
                              !conflict_reg && !free_found_reg;
            lock_count_reg <= count_wide[COUNT_W-1:0];
            released_reg   <= (req_op_reg == OP_RELEASE) ? rel_wide[COUNT_W-1:0]
                                                         : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            count_reg      <= '0;
            held_reg       <= 1'b0;
            conflict_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            rel_cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                held_reg       <= 1'b0;
                conflict_reg   <= 1'b0;
                free_found_reg <= 1'b0;
                rel_cnt_reg    <= '0;
            end
            else if (cmd.cmp_en)
            begin
                if (req_op_reg == OP_RELEASE)
                begin
                    if (e_valid && txn_match)
                    begin
                        valid_reg[cmp_addr] <= 1'b0;
                        rel_cnt_reg         <= rel_cnt_reg + CNT_W'(1);
                    end
                end
                else if (!e_valid)
                begin
                    // lowest free entry wins
                    if (!free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_slot_reg  <= cmp_addr;
                    end
                end
                else if (key_match)
                begin
                    if (txn_match)
                    begin
                        held_reg <= 1'b1;
                    end
                    else if (e_excl || req_excl_reg)
                    begin
                        conflict_reg <= 1'b1;
                    end
                end
            end

            if (alloc)
            begin
                valid_reg[free_slot_reg] <= 1'b1;
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    assign granted        = granted_reg;
    assign table_full     = full_reg;
    assign lock_count     = lock_count_reg;
    assign released_count = released_reg;

    // lock count matches the valid bits whenever a new item is taken
    a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> int'(count_reg) == $countones(valid_reg))
        else $error("lock count out of step with valid bits");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= TABLE_ENTRIES)
        else $error("lock count above table size");

    a_alloc_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |-> !valid_reg[free_slot_reg])
        else $error("allocation into an occupied entry");

    a_alloc_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |=> valid_reg[$past(free_slot_reg)])
        else $error("allocated entry not marked valid");

endmodule

`default_nettype wire

// ===== hw/rtl/shared_exclusive_lock_table.sv =====
// Top level of the shared/exclusive lock table.
// Depends on slkt_pkg, slkt_if, slkt_ram, slkt_ctrl and slkt_dp.
`default_nettype none

// Shared/exclusive lock table. Each request item either acquires a lock
// (transaction, key of up to KEY_BYTES bytes, shared or exclusive) or
// releases every lock of a transaction, and produces exactly one response
// item. Key bytes at or above the (clamped) key length are ignored.
// An acquire is granted if the same transaction already holds the same key
// with the same length; otherwise it is refused on a conflict with another
// transaction where either lock is exclusive; otherwise the lowest free
// entry is filled, or table_full is flagged if there is none.
// Sequence: one item occupies the block from its accept cycle through a
// scan that reads one table entry per cycle through the single read port of
// the entry RAM, a drain state for the RAM's registered read data and a
// commit state that loads the result into the output register. Items are
// handled one at a time; a new request is accepted while the previous
// response is still waiting in the output register, and the commit state
// holds until that register frees.
// Entry valid bits are flip-flops cleared by reset, so no clearing pass is
// needed after reset.

module shared_exclusive_lock_table import slkt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int KEY_BYTES     = DEF_KEY_BYTES,
    parameter int TXN_BITS      = DEF_TXN_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    slkt_req_if.sink   req,
    slkt_rsp_if.source rsp
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    slkt_cmd_t     cmd;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] cmp_addr;

    // sequencer: scan, drain, commit
    slkt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .cmp_addr  (cmp_addr)
    );

    // table storage, compare logic and response register
    slkt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BYTES     (KEY_BYTES),
        .TXN_BITS      (TXN_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .cmp_addr       (cmp_addr),
        .operation      (req.operation),
        .txn_id         (req.txn_id),
        .lock_key       (req.lock_key),
        .key_length     (req.key_length),
        .lock_mode      (req.lock_mode),
        .granted        (rsp.granted),
        .table_full     (rsp.table_full),
        .lock_count     (rsp.lock_count),
        .released_count (rsp.released_count)
    );

endmodule

`default_nettype wire
